// ===== hdl/tlsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsr_pkg
// shared types and constants of the thick line span rasterizer
// ----------------------------------------------------------------------------
package tlsr_pkg;

    localparam int THICK_BITS = 8;
    localparam int COLOR_BITS = 16;
    localparam int HALF_BITS  = THICK_BITS - 1;

    // command code carried in tuser
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    // shape of the line being walked
    typedef struct packed {
        logic straight;
        logic flat;
        logic col_neg;
        logic row_neg;
    } line_flags_t;

endpackage

// ===== hdl/tlsr_setup.sv =====
// ----------------------------------------------------------------------------
// tlsr_setup
// decodes a start beat into walk state: deltas, directions, origin, error
// ----------------------------------------------------------------------------
module tlsr_setup #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]             start_x,
    input  logic [COORD_BITS-1:0]             start_y,
    input  logic [COORD_BITS-1:0]             end_x,
    input  logic [COORD_BITS-1:0]             end_y,
    input  logic [tlsr_pkg::THICK_BITS-1:0]   thickness,
    output tlsr_pkg::line_flags_t             flags,
    output logic [COORD_BITS-1:0]             delta_col,
    output logic [COORD_BITS-1:0]             delta_row,
    output logic [COORD_BITS-1:0]             cur_col,
    output logic [COORD_BITS-1:0]             cur_row,
    output logic signed [COORD_BITS+1:0]      error_init,
    output logic                              busy_init
);

    localparam int EW = COORD_BITS + 2;

    logic col_neg;
    logic row_neg;
    logic straight;

    assign col_neg   = end_x < start_x;
    assign row_neg   = end_y < start_y;
    assign delta_col = col_neg ? (start_x - end_x) : (end_x - start_x);
    assign delta_row = row_neg ? (start_y - end_y) : (end_y - start_y);
    assign straight  = (delta_col == '0) || (delta_row == '0);

    assign flags.straight = straight;
    assign flags.flat     = straight ? (delta_col != '0) : (delta_col >= delta_row);
    assign flags.col_neg  = col_neg;
    assign flags.row_neg  = row_neg;

    // straight lines start from their low corner
    assign cur_col = (straight && col_neg) ? end_x : start_x;
    assign cur_row = (straight && row_neg) ? end_y : start_y;

    assign error_init = straight ? '0
                      : ($signed({{(EW-COORD_BITS){1'b0}}, delta_col})
                         - $signed({{(EW-COORD_BITS){1'b0}}, delta_row}));

    assign busy_init = straight ? (thickness != '0) : 1'b1;

endmodule

// ===== hdl/tlsr_span.sv =====
// ----------------------------------------------------------------------------
// tlsr_span
// forms one span rectangle and the next bresenham walk position
// ----------------------------------------------------------------------------
module tlsr_span #(
    parameter int COORD_BITS = 10
) (
    input  tlsr_pkg::line_flags_t             flags,
    input  logic [COORD_BITS-1:0]             cur_col,
    input  logic [COORD_BITS-1:0]             cur_row,
    input  logic [COORD_BITS-1:0]             last_col,
    input  logic [COORD_BITS-1:0]             last_row,
    input  logic [COORD_BITS-1:0]             delta_col,
    input  logic [COORD_BITS-1:0]             delta_row,
    input  logic signed [COORD_BITS+1:0]      error_acc,
    input  logic [tlsr_pkg::THICK_BITS-1:0]   thick,
    output logic [COORD_BITS-1:0]             rect_x,
    output logic [COORD_BITS-1:0]             rect_y,
    output logic [COORD_BITS:0]               rect_w,
    output logic [COORD_BITS:0]               rect_h,
    output logic                              fin,
    output logic [COORD_BITS-1:0]             next_col,
    output logic [COORD_BITS-1:0]             next_row,
    output logic signed [COORD_BITS+1:0]      next_error
);

    localparam int EW = COORD_BITS + 2;
    localparam int WW = COORD_BITS + 1;

    logic [tlsr_pkg::HALF_BITS-1:0] half;
    logic [COORD_BITS-1:0]          half_ext;
    logic [COORD_BITS-1:0]          col_c;
    logic [COORD_BITS-1:0]          row_c;
    logic [WW-1:0]                  thick_w;
    logic [WW-1:0]                  thick_p1;
    logic [WW-1:0]                  dc_p1;
    logic [WW-1:0]                  dr_p1;
    logic signed [EW:0]             e2;
    logic signed [EW:0]             dc_s;
    logic signed [EW:0]             dr_s;
    logic signed [EW-1:0]           dc_e;
    logic signed [EW-1:0]           dr_e;
    logic                           step_row;
    logic                           step_col;

    assign half     = thick[tlsr_pkg::THICK_BITS-1:1];
    assign half_ext = {{(COORD_BITS-tlsr_pkg::HALF_BITS){1'b0}}, half};
    // centered origin clamps at zero
    assign col_c    = (cur_col >= half_ext) ? (cur_col - half_ext) : '0;
    assign row_c    = (cur_row >= half_ext) ? (cur_row - half_ext) : '0;

    assign thick_w  = {{(WW-tlsr_pkg::THICK_BITS){1'b0}}, thick};
    assign thick_p1 = thick_w + WW'(1);
    assign dc_p1    = {1'b0, delta_col} + WW'(1);
    assign dr_p1    = {1'b0, delta_row} + WW'(1);

    assign e2   = {error_acc, 1'b0};
    assign dc_s = $signed({{(EW+1-COORD_BITS){1'b0}}, delta_col});
    assign dr_s = $signed({{(EW+1-COORD_BITS){1'b0}}, delta_row});
    assign dc_e = $signed({{(EW-COORD_BITS){1'b0}}, delta_col});
    assign dr_e = $signed({{(EW-COORD_BITS){1'b0}}, delta_row});

    always_comb begin
        next_col   = cur_col;
        next_row   = cur_row;
        next_error = error_acc;
        step_row   = 1'b0;
        step_col   = 1'b0;
        if (flags.straight) begin
            rect_x = cur_col;
            rect_y = cur_row;
            rect_w = flags.flat ? dc_p1 : thick_w;
            rect_h = flags.flat ? thick_w : dr_p1;
            fin    = 1'b1;
        end else begin
            if (flags.flat) begin
                rect_x = cur_col;
                rect_y = row_c;
                rect_w = WW'(1);
                rect_h = thick_p1;
            end else begin
                rect_x = col_c;
                rect_y = cur_row;
                rect_w = thick_p1;
                rect_h = WW'(1);
            end
            fin = (cur_col == last_col) && (cur_row == last_row);
            if (!fin) begin
                step_row   = e2 < dc_s;
                step_col   = e2 > -dr_s;
                next_error = error_acc + (step_row ? dc_e : '0) - (step_col ? dr_e : '0);
                if (step_row) begin
                    next_row = flags.row_neg ? (cur_row - 1'b1) : (cur_row + 1'b1);
                end
                if (step_col) begin
                    next_col = flags.col_neg ? (cur_col - 1'b1) : (cur_col + 1'b1);
                end
            end
        end
    end

endmodule

// ===== hdl/thick_line_span_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// thick_line_span_rasterizer_core
// walks a thick line and, while a line is active, emits one fill rectangle per step beat
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries commands; s_tuser is the command: start loads a line
//   from s_tdata (endpoints, thickness, color) and produces no beat, step
//   asks for the next span of the loaded line
//   m_ channel carries one span rectangle per step beat while a line is
//   active; m_tlast marks the final span, after which the core is idle
//   a step beat with no active line, or a straight line of zero thickness,
//   produces nothing
// timing:
//   a beat is captured in the input register, processed by one bresenham
//   add-compare update once the output register can take a span, and its
//   span is registered in the output register, which drives m_tvalid
//   throughput is one beat per cycle while m_tready stays high, set by the
//   single error update loop through the walk registers
// reset: aresetn (synchronous, active low) empties both registers and
//   drops any active line
// stall: while m_tready is low the span holds in the output register; the
//   input register still takes one more beat, then s_tready drops
// ----------------------------------------------------------------------------
module thick_line_span_rasterizer_core #(
    parameter  int COORD_BITS = 10,
    // tdata widths: packed fields rounded up to whole bytes
    localparam int S_DW = ((4 * COORD_BITS + tlsr_pkg::THICK_BITS
                            + tlsr_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int M_DW = ((4 * COORD_BITS + 2
                            + tlsr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata, low bit up: start_x, start_y, end_x, end_y, thickness,
    // pixel_color, zero fill
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DW-1:0]        s_tdata,
    // s_tuser: cmd
    input  logic                   s_tuser,
    // m_tdata, low bit up: rect_x, rect_y, rect_w, rect_h, span_color,
    // zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DW-1:0]        m_tdata,
    output logic                   m_tlast
);

    localparam int CB   = COORD_BITS;
    localparam int EW   = COORD_BITS + 2;
    localparam int WW   = COORD_BITS + 1;
    localparam int TB   = tlsr_pkg::THICK_BITS;
    localparam int KB   = tlsr_pkg::COLOR_BITS;
    localparam int S_RAW = 4 * CB + TB + KB;
    localparam int M_RAW = 2 * CB + 2 * WW + KB;

    // input register
    logic                     in_valid_reg;
    tlsr_pkg::cmd_t           in_cmd_reg;
    logic [S_RAW-1:0]         in_data_reg;

    // walk state
    logic                     busy_reg;
    tlsr_pkg::line_flags_t    flags_reg;
    logic [CB-1:0]            cur_col_reg;
    logic [CB-1:0]            cur_row_reg;
    logic [CB-1:0]            last_col_reg;
    logic [CB-1:0]            last_row_reg;
    logic [CB-1:0]            delta_col_reg;
    logic [CB-1:0]            delta_row_reg;
    logic signed [EW-1:0]     error_reg;
    logic [TB-1:0]            thick_reg;
    logic [KB-1:0]            color_reg;

    // output register
    logic                     out_valid_reg;
    logic [M_RAW-1:0]         out_data_reg;
    logic                     out_last_reg;

    // unpacked input fields
    logic [CB-1:0]            f_start_x;
    logic [CB-1:0]            f_start_y;
    logic [CB-1:0]            f_end_x;
    logic [CB-1:0]            f_end_y;
    logic [TB-1:0]            f_thick;
    logic [KB-1:0]            f_color;

    // setup results
    tlsr_pkg::line_flags_t    su_flags;
    logic [CB-1:0]            su_dc;
    logic [CB-1:0]            su_dr;
    logic [CB-1:0]            su_col;
    logic [CB-1:0]            su_row;
    logic signed [EW-1:0]     su_err;
    logic                     su_busy;

    // span results
    logic [CB-1:0]            sp_x;
    logic [CB-1:0]            sp_y;
    logic [WW-1:0]            sp_w;
    logic [WW-1:0]            sp_h;
    logic                     sp_fin;
    logic [CB-1:0]            sp_col;
    logic [CB-1:0]            sp_row;
    logic signed [EW-1:0]     sp_err;

    logic                     fire;
    logic                     is_start;
    logic                     emit;

    assign f_start_x = in_data_reg[CB-1:0];
    assign f_start_y = in_data_reg[2*CB-1:CB];
    assign f_end_x   = in_data_reg[3*CB-1:2*CB];
    assign f_end_y   = in_data_reg[4*CB-1:3*CB];
    assign f_thick   = in_data_reg[4*CB+TB-1:4*CB];
    assign f_color   = in_data_reg[S_RAW-1:4*CB+TB];

    // process the held beat once the output register can take a span
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign is_start = (in_cmd_reg == tlsr_pkg::CMD_START);
    assign emit     = fire && !is_start && busy_reg;
    assign s_tready = !in_valid_reg || fire;

    tlsr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x    (f_start_x),
        .start_y    (f_start_y),
        .end_x      (f_end_x),
        .end_y      (f_end_y),
        .thickness  (f_thick),
        .flags      (su_flags),
        .delta_col  (su_dc),
        .delta_row  (su_dr),
        .cur_col    (su_col),
        .cur_row    (su_row),
        .error_init (su_err),
        .busy_init  (su_busy)
    );

    tlsr_span #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .flags      (flags_reg),
        .cur_col    (cur_col_reg),
        .cur_row    (cur_row_reg),
        .last_col   (last_col_reg),
        .last_row   (last_row_reg),
        .delta_col  (delta_col_reg),
        .delta_row  (delta_row_reg),
        .error_acc  (error_reg),
        .thick      (thick_reg),
        .rect_x     (sp_x),
        .rect_y     (sp_y),
        .rect_w     (sp_w),
        .rect_h     (sp_h),
        .fin        (sp_fin),
        .next_col   (sp_col),
        .next_row   (sp_row),
        .next_error (sp_err)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= tlsr_pkg::cmd_t'(s_tuser);
            in_data_reg <= s_tdata[S_RAW-1:0];
        end
    end

    // walk state: a start reloads, a step on an active line advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            flags_reg <= '0;
        end else if (fire && is_start) begin
            busy_reg      <= su_busy;
            flags_reg     <= su_flags;
            cur_col_reg   <= su_col;
            cur_row_reg   <= su_row;
            last_col_reg  <= f_end_x;
            last_row_reg  <= f_end_y;
            delta_col_reg <= su_dc;
            delta_row_reg <= su_dr;
            error_reg     <= su_err;
            thick_reg     <= f_thick;
            color_reg     <= f_color;
        end else if (emit) begin
            busy_reg    <= !sp_fin;
            cur_col_reg <= sp_col;
            cur_row_reg <= sp_row;
            error_reg   <= sp_err;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (emit) begin
            out_data_reg <= {color_reg, sp_h, sp_w, sp_y, sp_x};
            out_last_reg <= sp_fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DW-M_RAW){1'b0}}, out_data_reg};
    assign m_tlast  = out_last_reg;

    // the input register is full whenever the core back-pressures
    a_ready_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("s_tready low with empty input register");

    // a straight line always finishes in one span
    a_straight_one : assert property (@(posedge aclk) disable iff (!aresetn)
        emit && flags_reg.straight |=> m_tvalid && m_tlast && !busy_reg)
        else $error("straight line span without last");

    // spans are never empty
    a_span_size : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*CB+WW-1:2*CB] != '0) && (m_tdata[2*CB+2*WW-1:2*CB+WW] != '0))
        else $error("zero sized span");

    // the last span of a line leaves the core idle
    a_last_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        emit && sp_fin |=> !busy_reg)
        else $error("core still busy after last span");

endmodule
